// File: design/stlms_pkg.sv
// Package for the scrolling text LED matrix scanner.
// Holds field widths, register codes, the lane control struct and the glyph ROM.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package stlms_pkg;

  // Design defaults
  localparam int MaxTextDefault  = 32;
  localparam int LeadBlankDefault = 24;

  // Field widths
  localparam int OpcodeW   = 1;
  localparam int CharIdxW  = 5;
  localparam int CharCodeW = 7;
  localparam int ByteW     = 8;
  localparam int ColCntW   = 3;
  localparam int OffsetW   = 9;
  localparam int TextLenW  = 6;
  localparam int FpsW      = 8;
  localparam int CharsW    = 7;   // holds a character count up to 127
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 8;

  // Display geometry
  localparam int NumLanes   = 3;
  localparam int GlyphCols  = 8;
  localparam int GlyphRomW  = 10;
  localparam int GlyphCount = 94;

  localparam logic [CharCodeW-1:0] GlyphFirst = 7'd33;
  localparam logic [CharCodeW-1:0] GlyphLast  = 7'd126;

  localparam logic [TextLenW-1:0] TextLenReset = 6'd10;
  localparam logic [FpsW-1:0]     FpsReset     = 8'd3;

  localparam logic [OpcodeW-1:0] OpWrite = 1'b0;
  localparam logic [OpcodeW-1:0] OpTick  = 1'b1;

  localparam logic [ColCntW-1:0] LastCol     = 3'd7;
  localparam logic [ByteW-1:0]   StrobeFixed = 8'h80;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgTextLength   = 1'b0,
    CfgFramesPerStep = 1'b1
  } cfg_reg_e;

  // Control from the top level to each lane
  typedef struct packed {
    logic                 wr_en;
    logic [CharIdxW-1:0]  wr_index;
    logic [CharCodeW-1:0] wr_code;
    logic                 s1_en;
    logic                 s2_en;
  } lane_ctrl_t;

  // Largest scroll offset the state can hold
  function automatic int strip_max(input int max_text, input int lead);
    return lead + GlyphCols * max_text;
  endfunction

  // Width of a scroll offset
  function automatic int pos_w(input int max_text, input int lead);
    return $clog2(strip_max(max_text, lead) + 1);
  endfunction

  // Width of a strip column as seen by the rightmost matrix
  function automatic int strip_col_w(input int max_text, input int lead);
    return $clog2(strip_max(max_text, lead) + NumLanes * GlyphCols);
  endfunction

  // Glyph columns for codes 33..126, eight per glyph
  localparam logic [ByteW-1:0] GLYPH_ROM [GlyphCount*GlyphCols] = '{
    8'h00,8'h00,8'h60,8'hFA,8'hFA,8'h60,8'h00,8'h00,
    8'h00,8'hC0,8'hE0,8'h00,8'h00,8'hE0,8'hC0,8'h00,
    8'h28,8'hFE,8'hFE,8'h28,8'hFE,8'hFE,8'h28,8'h00,
    8'h00,8'h24,8'h74,8'hD6,8'hD6,8'h5C,8'h48,8'h00,
    8'h62,8'h66,8'h0C,8'h18,8'h30,8'h66,8'h46,8'h00,
    8'h0C,8'h5E,8'hF2,8'hBA,8'hEC,8'h5E,8'h12,8'h00,
    8'h00,8'h00,8'h20,8'hE0,8'hC0,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h38,8'h7C,8'hC6,8'h82,8'h00,8'h00,
    8'h00,8'h00,8'h82,8'hC6,8'h7C,8'h38,8'h00,8'h00,
    8'h10,8'h54,8'h7C,8'h38,8'h38,8'h7C,8'h54,8'h10,
    8'h00,8'h10,8'h10,8'h7C,8'h7C,8'h10,8'h10,8'h00,
    8'h00,8'h00,8'h01,8'h07,8'h06,8'h00,8'h00,8'h00,
    8'h00,8'h10,8'h10,8'h10,8'h10,8'h10,8'h10,8'h00,
    8'h00,8'h00,8'h00,8'h06,8'h06,8'h00,8'h00,8'h00,
    8'h06,8'h0C,8'h18,8'h30,8'h60,8'hC0,8'h80,8'h00,
    8'h38,8'h7C,8'hC6,8'h92,8'hC6,8'h7C,8'h38,8'h00,
    8'h00,8'h02,8'h42,8'hFE,8'hFE,8'h02,8'h02,8'h00,
    8'h42,8'hC6,8'h8E,8'h9A,8'h92,8'hF6,8'h66,8'h00,
    8'h44,8'hC6,8'h92,8'h92,8'h92,8'hFE,8'h6C,8'h00,
    8'h18,8'h38,8'h68,8'hCA,8'hFE,8'hFE,8'h0A,8'h00,
    8'hF4,8'hF6,8'h92,8'h92,8'h92,8'h9E,8'h8C,8'h00,
    8'h3C,8'h7E,8'hD2,8'h92,8'h92,8'h1E,8'h0C,8'h00,
    8'hC0,8'hC0,8'h8E,8'h9E,8'hB0,8'hE0,8'hC0,8'h00,
    8'h6C,8'hFE,8'h92,8'h92,8'h92,8'hFE,8'h6C,8'h00,
    8'h60,8'hF2,8'h92,8'h92,8'h96,8'hFC,8'h78,8'h00,
    8'h00,8'h00,8'h00,8'h66,8'h66,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h01,8'h67,8'h66,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h10,8'h38,8'h6C,8'hC6,8'h82,8'h00,
    8'h00,8'h24,8'h24,8'h24,8'h24,8'h24,8'h24,8'h00,
    8'h00,8'h82,8'hC6,8'h6C,8'h38,8'h10,8'h00,8'h00,
    8'h40,8'hC0,8'h80,8'h9A,8'hBA,8'hE0,8'h40,8'h00,
    8'h7C,8'hFE,8'h82,8'hBA,8'hBA,8'hF8,8'h78,8'h00,
    8'h3E,8'h7E,8'hD0,8'h90,8'hD0,8'h7E,8'h3E,8'h00,
    8'h82,8'hFE,8'hFE,8'h92,8'h92,8'hFE,8'h6C,8'h00,
    8'h38,8'h7C,8'hC6,8'h82,8'h82,8'hC6,8'h44,8'h00,
    8'h82,8'hFE,8'hFE,8'h82,8'hC6,8'h7C,8'h38,8'h00,
    8'h82,8'hFE,8'hFE,8'h92,8'hBA,8'h82,8'hC6,8'h00,
    8'h82,8'hFE,8'hFE,8'h92,8'hB8,8'h80,8'hC0,8'h00,
    8'h38,8'h7C,8'hC6,8'h82,8'h8A,8'hCC,8'h4E,8'h00,
    8'hFE,8'hFE,8'h10,8'h10,8'h10,8'hFE,8'hFE,8'h00,
    8'h00,8'h00,8'h82,8'hFE,8'hFE,8'h82,8'h00,8'h00,
    8'h0C,8'h0E,8'h02,8'h82,8'hFE,8'hFC,8'h80,8'h00,
    8'h82,8'hFE,8'hFE,8'h10,8'h38,8'hEE,8'hC6,8'h00,
    8'h82,8'hFE,8'hFE,8'h82,8'h02,8'h06,8'h0E,8'h00,
    8'hFE,8'hFE,8'h70,8'h38,8'h70,8'hFE,8'hFE,8'h00,
    8'hFE,8'hFE,8'h60,8'h30,8'h18,8'hFE,8'hFE,8'h00,
    8'h7C,8'hFE,8'h82,8'h82,8'h82,8'hFE,8'h7C,8'h00,
    8'h82,8'hFE,8'hFE,8'h92,8'h90,8'hF0,8'h60,8'h00,
    8'h7C,8'hFE,8'h82,8'h82,8'h87,8'hFF,8'h7D,8'h00,
    8'h82,8'hFE,8'hFE,8'h90,8'h98,8'hFE,8'h66,8'h00,
    8'h00,8'h44,8'hE6,8'hB2,8'h9A,8'hCE,8'h44,8'h00,
    8'h00,8'hE0,8'hC2,8'hFE,8'hFE,8'hC2,8'hE0,8'h00,
    8'hFC,8'hFE,8'h02,8'h02,8'h02,8'hFE,8'hFC,8'h00,
    8'hF8,8'hFC,8'h06,8'h02,8'h06,8'hFC,8'hF8,8'h00,
    8'hFC,8'hFE,8'h06,8'h1C,8'h06,8'hFE,8'hFC,8'h00,
    8'hC6,8'hEE,8'h38,8'h10,8'h38,8'hEE,8'hC6,8'h00,
    8'h00,8'hE0,8'hF2,8'h1E,8'h1E,8'hF2,8'hE0,8'h00,
    8'hE2,8'hC6,8'h8E,8'h9A,8'hB2,8'hE6,8'hCE,8'h00,
    8'h00,8'h00,8'hFE,8'hFE,8'h82,8'h82,8'h00,8'h00,
    8'h80,8'hC0,8'h60,8'h30,8'h18,8'h0C,8'h06,8'h00,
    8'h00,8'h00,8'h82,8'h82,8'hFE,8'hFE,8'h00,8'h00,
    8'h10,8'h30,8'h60,8'hC0,8'h60,8'h30,8'h10,8'h00,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h00,8'h00,8'h20,8'hE0,8'hC0,8'h00,8'h00,8'h00,
    8'h04,8'h2E,8'h2A,8'h2A,8'h3C,8'h1E,8'h02,8'h00,
    8'h82,8'hFE,8'hFC,8'h22,8'h22,8'h3E,8'h1C,8'h00,
    8'h1C,8'h3E,8'h22,8'h22,8'h22,8'h36,8'h14,8'h00,
    8'h1C,8'h3E,8'h22,8'hA2,8'hFC,8'hFE,8'h02,8'h00,
    8'h1C,8'h3E,8'h2A,8'h2A,8'h2A,8'h3A,8'h18,8'h00,
    8'h12,8'h7E,8'hFE,8'h92,8'h90,8'hC0,8'h40,8'h00,
    8'h19,8'h3D,8'h25,8'h25,8'h1F,8'h3E,8'h20,8'h00,
    8'h82,8'hFE,8'hFE,8'h10,8'h20,8'h3E,8'h1E,8'h00,
    8'h00,8'h00,8'h22,8'hBE,8'hBE,8'h02,8'h00,8'h00,
    8'h00,8'h06,8'h07,8'h01,8'h01,8'hBF,8'hBE,8'h00,
    8'h82,8'hFE,8'hFE,8'h08,8'h1C,8'h36,8'h22,8'h00,
    8'h00,8'h00,8'h82,8'hFE,8'hFE,8'h02,8'h00,8'h00,
    8'h3E,8'h3E,8'h30,8'h1E,8'h30,8'h3E,8'h1E,8'h00,
    8'h20,8'h3E,8'h1E,8'h20,8'h20,8'h3E,8'h1E,8'h00,
    8'h1C,8'h3E,8'h22,8'h22,8'h22,8'h3E,8'h1C,8'h00,
    8'h21,8'h3F,8'h1F,8'h25,8'h24,8'h3C,8'h18,8'h00,
    8'h18,8'h3C,8'h24,8'h25,8'h1F,8'h3F,8'h21,8'h00,
    8'h22,8'h3E,8'h1E,8'h32,8'h20,8'h30,8'h10,8'h00,
    8'h12,8'h3A,8'h2A,8'h2A,8'h2A,8'h2E,8'h24,8'h00,
    8'h20,8'h20,8'hFC,8'hFE,8'h22,8'h26,8'h04,8'h00,
    8'h3C,8'h3E,8'h02,8'h02,8'h3C,8'h3E,8'h02,8'h00,
    8'h38,8'h3C,8'h06,8'h02,8'h06,8'h3C,8'h38,8'h00,
    8'h3C,8'h3E,8'h06,8'h1C,8'h06,8'h3E,8'h3C,8'h00,
    8'h22,8'h36,8'h1C,8'h08,8'h1C,8'h36,8'h22,8'h00,
    8'h39,8'h3D,8'h05,8'h05,8'h05,8'h3F,8'h3E,8'h00,
    8'h00,8'h32,8'h26,8'h2E,8'h3A,8'h32,8'h26,8'h00,
    8'h00,8'h10,8'h10,8'h7C,8'hEE,8'h82,8'h82,8'h00,
    8'h00,8'h00,8'h00,8'hFE,8'hFE,8'h00,8'h00,8'h00,
    8'h00,8'h82,8'h82,8'hEE,8'h7C,8'h10,8'h10,8'h00,
    8'h40,8'hC0,8'h80,8'hC0,8'h40,8'hC0,8'h80,8'h00
  };

endpackage

`default_nettype wire

// File: design/stlms_in_if.sv
// Request channel into the scanner: character writes and scan ticks.
// Depends on stlms_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface stlms_in_if;
  logic                            valid;
  logic                            ready;
  logic [stlms_pkg::OpcodeW-1:0]   opcode;
  logic [stlms_pkg::CharIdxW-1:0]  char_index;
  logic [stlms_pkg::CharCodeW-1:0] char_code;

  modport source (output valid, output opcode, output char_index, output char_code,
                  input ready);
  modport sink   (input valid, input opcode, input char_index, input char_code,
                  output ready);
endinterface

`default_nettype wire

// File: design/stlms_out_if.sv
// Result channel out of the scanner: one column period per tick request.
// Depends on stlms_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface stlms_out_if;
  logic                          valid;
  logic                          ready;
  logic [stlms_pkg::ByteW-1:0]   left_byte;
  logic [stlms_pkg::ByteW-1:0]   middle_byte;
  logic [stlms_pkg::ByteW-1:0]   right_byte;
  logic [stlms_pkg::ByteW-1:0]   column_select;
  logic [stlms_pkg::OffsetW-1:0] scroll_offset;
  logic                          frame_end;

  modport source (output valid, output left_byte, output middle_byte, output right_byte,
                  output column_select, output scroll_offset, output frame_end,
                  input ready);
  modport sink   (input valid, input left_byte, input middle_byte, input right_byte,
                  input column_select, input scroll_offset, input frame_end,
                  output ready);
endinterface

`default_nettype wire

// File: design/stlms_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on stlms_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface stlms_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [stlms_pkg::CfgIdxW-1:0]  reg_index;
  logic [stlms_pkg::CfgDataW-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// File: design/stlms_lane.sv
// One matrix lane: own copy of the text store, glyph ROM lookup, two stages.
// Depends on stlms_pkg (lane_ctrl_t, GLYPH_ROM, widths).
`timescale 1ns / 1ps
`default_nettype none

module stlms_lane #(
  parameter int MAX_TEXT           = stlms_pkg::MaxTextDefault,
  parameter int LEAD_BLANK_COLUMNS = stlms_pkg::LeadBlankDefault
) (
  input  wire                                   clk_i,
  input  wire stlms_pkg::lane_ctrl_t            ctrl_i,
  input  wire [stlms_pkg::strip_col_w(MAX_TEXT, LEAD_BLANK_COLUMNS)-1:0] strip_col_i,
  input  wire [stlms_pkg::CharsW-1:0]           chars_i,
  output logic [stlms_pkg::ByteW-1:0]           byte_o
);

  localparam int ColW = stlms_pkg::strip_col_w(MAX_TEXT, LEAD_BLANK_COLUMNS);
  localparam int AddrW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam int CmpW = (ColW > stlms_pkg::CharsW) ? ColW : stlms_pkg::CharsW;
  localparam logic [ColW-1:0] LeadCols = ColW'(LEAD_BLANK_COLUMNS);

  logic [stlms_pkg::CharCodeW-1:0] text_mem_q [MAX_TEXT];

  logic [ColW-1:0]  rel_col;
  logic [ColW-1:0]  char_pos;
  logic             in_text;
  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] wr_addr;

  logic [stlms_pkg::CharCodeW-1:0] code_q;
  logic                            in_text_q;
  logic [2:0]                      sub_q;

  logic                             glyph_ok;
  logic [stlms_pkg::CharCodeW-1:0]  glyph_num;
  logic [stlms_pkg::GlyphRomW-1:0]  rom_addr;
  logic [stlms_pkg::ByteW-1:0]      rom_q;
  logic                             show_q;

  // Stage 0: which character of the text this strip column belongs to
  always_comb begin
    rel_col  = strip_col_i - LeadCols;
    char_pos = rel_col >> 3;
    in_text  = (strip_col_i >= LeadCols) && (CmpW'(char_pos) < CmpW'(chars_i));
    rd_addr  = in_text ? char_pos[AddrW-1:0] : '0;
    wr_addr  = AddrW'(ctrl_i.wr_index);
  end

  // Text store copy, registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      text_mem_q[wr_addr] <= ctrl_i.wr_code;
    end
    if (ctrl_i.s1_en) begin
      code_q    <= text_mem_q[rd_addr];
      in_text_q <= in_text;
      sub_q     <= rel_col[2:0];
    end
  end

  // Stage 1: glyph ROM address, blank for codes without a glyph
  always_comb begin
    glyph_ok  = in_text_q && (code_q >= stlms_pkg::GlyphFirst) &&
                (code_q <= stlms_pkg::GlyphLast);
    glyph_num = code_q - stlms_pkg::GlyphFirst;
    rom_addr  = glyph_ok ? {glyph_num, sub_q} : '0;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s2_en) begin
      rom_q  <= stlms_pkg::GLYPH_ROM[rom_addr];
      show_q <= glyph_ok;
    end
  end

  // Stage 2 result
  assign byte_o = show_q ? rom_q : '0;

endmodule

`default_nettype wire

// File: design/stlms_scan.sv
// Scan sequencer: column counter, frame counter and scroll offset.
// Depends on stlms_pkg for widths and constants.
`timescale 1ns / 1ps
`default_nettype none

module stlms_scan #(
  parameter int MAX_TEXT           = stlms_pkg::MaxTextDefault,
  parameter int LEAD_BLANK_COLUMNS = stlms_pkg::LeadBlankDefault
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  tick_i,
  input  wire [stlms_pkg::CharsW-1:0]          chars_i,
  input  wire [stlms_pkg::FpsW-1:0]            fps_i,
  output logic [stlms_pkg::ColCntW-1:0]        col_o,
  output logic [stlms_pkg::pos_w(MAX_TEXT, LEAD_BLANK_COLUMNS)-1:0] pos_o
);

  localparam int PosW = stlms_pkg::pos_w(MAX_TEXT, LEAD_BLANK_COLUMNS);

  logic [stlms_pkg::ColCntW-1:0] col_q, col_d;
  logic [stlms_pkg::FpsW-1:0]    frame_q, frame_d;
  logic [PosW-1:0]               pos_q, pos_d;

  logic [stlms_pkg::FpsW:0]   frame_inc;
  logic [stlms_pkg::FpsW-1:0] fps_eff;
  logic [PosW-1:0]            limit;

  // Next state on each accepted tick
  always_comb begin
    col_d     = col_q;
    frame_d   = frame_q;
    pos_d     = pos_q;
    fps_eff   = (fps_i == '0) ? stlms_pkg::FpsW'(1) : fps_i;
    frame_inc = {1'b0, frame_q} + (stlms_pkg::FpsW + 1)'(1);
    limit     = PosW'(LEAD_BLANK_COLUMNS) + (PosW'(chars_i) << 3);
    if (tick_i) begin
      col_d = col_q + stlms_pkg::ColCntW'(1);
      if (col_q == stlms_pkg::LastCol) begin
        if (frame_inc >= {1'b0, fps_eff}) begin
          frame_d = '0;
          pos_d   = (pos_q >= limit) ? '0 : pos_q + PosW'(1);
        end else begin
          frame_d = frame_inc[stlms_pkg::FpsW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      frame_q <= '0;
      pos_q   <= '0;
    end else begin
      col_q   <= col_d;
      frame_q <= frame_d;
      pos_q   <= pos_d;
    end
  end

  assign col_o = col_q;
  assign pos_o = pos_q;

endmodule

`default_nettype wire

// File: design/scrolling_text_led_matrix_scanner_unit.sv
// Top level of the scrolling text scanner for three side-by-side 8x8 matrices.
// Depends on stlms_pkg, the three channel interfaces, stlms_scan and stlms_lane.
//
// Use:
//   in_i carries requests. opcode write stores char_code at char_index and gives
//   no result; opcode tick gives one column period on out_o. cfg_i writes the
//   character count (index 0) and frames_per_step (index 1); it is always ready
//   and the user must write it only while the block is idle (not enforced).
// Timing:
//   A tick's result passes the text store read (at the taking edge), the glyph
//   ROM read and the output register. One request is taken per cycle while
//   in_i.ready is high; the three lanes look up the three matrices in parallel,
//   each with its own copy of the text store, and the output register merges.
// Reset:
//   Column, frame and scroll counters clear, the character count is 10,
//   frames_per_step is 3, the pipeline empties. The text store holds nothing
//   defined until written.
// Stall:
//   While out_o is held, stages behind it keep filling; in_i.ready drops only
//   once all three stages hold a tick.
`timescale 1ns / 1ps
`default_nettype none

module scrolling_text_led_matrix_scanner_unit #(
  parameter int MAX_TEXT           = stlms_pkg::MaxTextDefault,
  parameter int LEAD_BLANK_COLUMNS = stlms_pkg::LeadBlankDefault
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  stlms_in_if.sink   in_i,
  stlms_cfg_if.sink  cfg_i,
  stlms_out_if.source out_o
);

  localparam int PosW = stlms_pkg::pos_w(MAX_TEXT, LEAD_BLANK_COLUMNS);
  localparam int ColW = stlms_pkg::strip_col_w(MAX_TEXT, LEAD_BLANK_COLUMNS);
  localparam int StripMax = stlms_pkg::strip_max(MAX_TEXT, LEAD_BLANK_COLUMNS);
  localparam logic [stlms_pkg::CharsW-1:0] MaxTextC = stlms_pkg::CharsW'(MAX_TEXT);

  // Configuration registers
  logic [stlms_pkg::TextLenW-1:0] len_cfg_q;
  logic [stlms_pkg::FpsW-1:0]     fps_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q <= stlms_pkg::TextLenReset;
      fps_q     <= stlms_pkg::FpsReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        stlms_pkg::CfgTextLength:    len_cfg_q <= cfg_i.wdata[stlms_pkg::TextLenW-1:0];
        stlms_pkg::CfgFramesPerStep: fps_q <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // Characters in use, limited to the store depth
  logic [stlms_pkg::CharsW-1:0] tl_ext;
  logic [stlms_pkg::CharsW-1:0] chars;
  assign tl_ext = stlms_pkg::CharsW'(len_cfg_q);
  assign chars  = (tl_ext > MaxTextC) ? MaxTextC : tl_ext;

  // Pipeline handshake: each stage moves when the next one is free or moving
  logic v1_q, v2_q, ov_q;
  logic en1, en2, en3;
  logic in_acc, tick, wr;

  assign en3 = !ov_q || out_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  assign in_acc = in_i.valid && en1;
  assign tick   = in_acc && (in_i.opcode == stlms_pkg::OpTick);
  assign wr     = in_acc && (in_i.opcode == stlms_pkg::OpWrite) &&
                  (stlms_pkg::CharsW'(in_i.char_index) < MaxTextC);

  // Scan sequencer
  logic [stlms_pkg::ColCntW-1:0] scan_col;
  logic [PosW-1:0]               scan_pos;

  stlms_scan #(
    .MAX_TEXT           (MAX_TEXT),
    .LEAD_BLANK_COLUMNS (LEAD_BLANK_COLUMNS)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick),
    .chars_i (chars),
    .fps_i   (fps_q),
    .col_o   (scan_col),
    .pos_o   (scan_pos)
  );

  // Lanes, one per matrix
  stlms_pkg::lane_ctrl_t lane_ctrl;
  logic [stlms_pkg::ByteW-1:0] lane_byte [stlms_pkg::NumLanes];

  always_comb begin
    lane_ctrl.wr_en    = wr;
    lane_ctrl.wr_index = in_i.char_index;
    lane_ctrl.wr_code  = in_i.char_code;
    lane_ctrl.s1_en    = en1;
    lane_ctrl.s2_en    = en2;
  end

  for (genvar m = 0; m < stlms_pkg::NumLanes; m++) begin : g_lane
    logic [ColW-1:0] strip_col;
    assign strip_col = ColW'(scan_pos) + ColW'(m * stlms_pkg::GlyphCols) +
                       ColW'(scan_col);

    stlms_lane #(
      .MAX_TEXT           (MAX_TEXT),
      .LEAD_BLANK_COLUMNS (LEAD_BLANK_COLUMNS)
    ) u_lane (
      .clk_i       (clk_i),
      .ctrl_i      (lane_ctrl),
      .strip_col_i (strip_col),
      .chars_i     (chars),
      .byte_o      (lane_byte[m])
    );
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (en1) v1_q <= tick;
      if (en2) v2_q <= v1_q;
      if (en3) ov_q <= v2_q;
    end
  end

  // Column and offset travel alongside the lane stages
  logic [stlms_pkg::ColCntW-1:0] col1_q, col2_q;
  logic [PosW-1:0]               pos1_q, pos2_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      col1_q <= scan_col;
      pos1_q <= scan_pos;
    end
    if (en2) begin
      col2_q <= col1_q;
      pos2_q <= pos1_q;
    end
  end

  // Merge: output register
  logic [stlms_pkg::ByteW-1:0]   left_q, middle_q, right_q, colsel_q;
  logic [stlms_pkg::OffsetW-1:0] offset_q;
  logic                          fend_q;
  logic [stlms_pkg::ByteW-1:0]   strobe;

  assign strobe = stlms_pkg::StrobeFixed |
                  ((stlms_pkg::ByteW'(1) << col2_q) & ~stlms_pkg::StrobeFixed);

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      left_q   <= lane_byte[0];
      middle_q <= lane_byte[1];
      right_q  <= lane_byte[2];
      colsel_q <= strobe;
      offset_q <= stlms_pkg::OffsetW'(pos2_q);
      fend_q   <= (col2_q == stlms_pkg::LastCol);
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.left_byte     = left_q;
  assign out_o.middle_byte   = middle_q;
  assign out_o.right_byte    = right_q;
  assign out_o.column_select = colsel_q;
  assign out_o.scroll_offset = offset_q;
  assign out_o.frame_end     = fend_q;

  // Checks
  // Scroll offset never passes the wrap point of the longest text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_pos <= PosW'(StripMax))
    else $error("scroll offset beyond strip");

  // Request side stalls only when every stage is full and the output is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (ov_q && v2_q && v1_q && !out_o.ready))
    else $error("request stalled with room in pipeline");

  // A held result keeps the tick behind it in place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && ov_q && !out_o.ready) |=> v2_q)
    else $error("stage two tick lost during stall");

endmodule

`default_nettype wire
